// ===== rtl/fcmt_pkg.sv =====
// Package for the f64 compare / min-max / truncate unit.
// Holds operation codes, limit constants and bit-pattern helper functions.
// Depends on nothing.
package fcmt_pkg;

  typedef enum logic [4:0] {
    OP_ABS = 5'd0, OP_NEG = 5'd1, OP_COPYSIGN = 5'd2, OP_MIN = 5'd3, OP_MAX = 5'd4,
    OP_EQ = 5'd5, OP_NE = 5'd6, OP_LT = 5'd7, OP_LE = 5'd8, OP_GT = 5'd9, OP_GE = 5'd10,
    OP_I32S_T = 5'd11, OP_I32S_S = 5'd12, OP_I32U_T = 5'd13, OP_I32U_S = 5'd14,
    OP_I64S_T = 5'd15, OP_I64S_S = 5'd16, OP_I64U_T = 5'd17, OP_I64U_S = 5'd18
  } action_e;

  localparam logic [63:0] SignBit   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LimI32sHi = 64'h41e0_0000_0000_0000;
  localparam logic [63:0] LimI32sLo = 64'hc1e0_0000_0020_0000;
  localparam logic [63:0] LimU32Hi  = 64'h41f0_0000_0000_0000;
  localparam logic [63:0] LimULo    = 64'hbff0_0000_0000_0000;
  localparam logic [63:0] LimI64sHi = 64'h43e0_0000_0000_0000;
  localparam logic [63:0] LimI64sLo = 64'hc3e0_0000_0000_0001;
  localparam logic [63:0] LimU64Hi  = 64'h43f0_0000_0000_0000;
  localparam logic [63:0] I32MaxBits = 64'd2147483647;
  localparam logic [63:0] I32MinBits = 64'h0000_0000_8000_0000;
  localparam logic [63:0] I64MaxBits = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] U32MaxBits = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] U64MaxBits = 64'hffff_ffff_ffff_ffff;

  function automatic logic is_nan(logic [63:0] x);
    return (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_zero(logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  // Unsigned key that orders non-NaN values; both zeros map to one key.
  function automatic logic [63:0] order_key(logic [63:0] x);
    logic [63:0] y;
    y = is_zero(x) ? 64'd0 : x;
    return y[63] ? ~y : (y | SignBit);
  endfunction

  function automatic logic f_le(logic [63:0] a, logic [63:0] b);
    return !is_nan(a) && !is_nan(b) && (order_key(a) <= order_key(b));
  endfunction

  function automatic logic f_lt(logic [63:0] a, logic [63:0] b);
    return !is_nan(a) && !is_nan(b) && (order_key(a) < order_key(b));
  endfunction

endpackage

// ===== rtl/f64_compare_minmax_truncate_unit_top.sv =====
// Top level of the f64 compare / min-max / truncate unit.
// Depends on fcmt_pkg and fcmt_trunc.
//
// Usage: an operation beat arrives on the s_axis channel; tuser carries the
// action code and tdata the two binary64 operands. The m_axis channel gives
// one result beat for each input beat: tdata holds the 64-bit result and
// tuser holds the trap flag.
// The input beat is captured in an input register; the whole operation is
// evaluated in one combinational pass from that register into a result
// register, which drives the result beat. Throughput is one beat per cycle
// while the receiver does not stall, set by that single pass.
// Both registers advance together whenever the result register is empty
// or being drained, so s_axis_tready follows m_axis_tready as a pipeline
// enable. When the receiver stalls, both stages hold their beats and
// s_axis_tready falls once both are full.
// Reset clears both valid flags; no beats are pending after reset.
// Undefined action codes give result 0 and no trap.
module f64_compare_minmax_truncate_unit_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [63:0] operand_a, [127:64] operand_b
  input  logic [4:0]   s_axis_tuser,  // [4:0] action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // [63:0] result_bits
  output logic         m_axis_tuser   // [0] trap
);
  logic        in_vld_q, out_vld_q, adv_w;
  logic [4:0]  act_q;
  logic [63:0] a_q, b_q, res_q, res_d, mag_w, strunc_w;
  logic        trap_q, trap_d;

  // The pipe moves whenever the result stage can accept a beat.
  assign adv_w         = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv_w || !in_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = trap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_w) out_vld_q <= in_vld_q;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      act_q <= s_axis_tuser;
      a_q   <= s_axis_tdata[63:0];
      b_q   <= s_axis_tdata[127:64];
    end
    if (adv_w && in_vld_q) begin
      res_q  <= res_d;
      trap_q <= trap_d;
    end
  end

  fcmt_trunc u_trunc (.value_i(a_q), .mag_o(mag_w));

  assign strunc_w = a_q[63] ? (64'd0 - mag_w) : mag_w;

  always_comb begin
    logic nan_a, nan_b, zz;
    nan_a  = fcmt_pkg::is_nan(a_q);
    nan_b  = fcmt_pkg::is_nan(b_q);
    zz     = fcmt_pkg::is_zero(a_q) && fcmt_pkg::is_zero(b_q) && (a_q[63] != b_q[63]);
    res_d  = 64'd0;
    trap_d = 1'b0;
    case (act_q)
      fcmt_pkg::OP_ABS:      res_d = a_q & ~fcmt_pkg::SignBit;
      fcmt_pkg::OP_NEG:      res_d = a_q ^ fcmt_pkg::SignBit;
      fcmt_pkg::OP_COPYSIGN: res_d = {b_q[63], a_q[62:0]};
      fcmt_pkg::OP_MIN: begin
        if (nan_a) res_d = a_q;
        else if (nan_b) res_d = b_q;
        else if (zz) res_d = fcmt_pkg::SignBit;
        else res_d = fcmt_pkg::f_lt(b_q, a_q) ? b_q : a_q;
      end
      fcmt_pkg::OP_MAX: begin
        if (nan_a) res_d = a_q;
        else if (nan_b) res_d = b_q;
        else if (zz) res_d = 64'd0;
        else res_d = fcmt_pkg::f_lt(a_q, b_q) ? b_q : a_q;
      end
      fcmt_pkg::OP_EQ: res_d = {63'd0, fcmt_pkg::f_le(a_q, b_q) && fcmt_pkg::f_le(b_q, a_q)};
      fcmt_pkg::OP_NE: res_d = {63'd0, !(fcmt_pkg::f_le(a_q, b_q) && fcmt_pkg::f_le(b_q, a_q))};
      fcmt_pkg::OP_LT: res_d = {63'd0, fcmt_pkg::f_lt(a_q, b_q)};
      fcmt_pkg::OP_LE: res_d = {63'd0, fcmt_pkg::f_le(a_q, b_q)};
      fcmt_pkg::OP_GT: res_d = {63'd0, fcmt_pkg::f_lt(b_q, a_q)};
      fcmt_pkg::OP_GE: res_d = {63'd0, fcmt_pkg::f_le(b_q, a_q)};
      fcmt_pkg::OP_I32S_T: begin
        if (nan_a || fcmt_pkg::f_le(fcmt_pkg::LimI32sHi, a_q)
            || fcmt_pkg::f_le(a_q, fcmt_pkg::LimI32sLo)) trap_d = 1'b1;
        else res_d = {32'd0, strunc_w[31:0]};
      end
      fcmt_pkg::OP_I32S_S: begin
        if (nan_a) res_d = 64'd0;
        else if (fcmt_pkg::f_le(fcmt_pkg::LimI32sHi, a_q)) res_d = fcmt_pkg::I32MaxBits;
        else if (fcmt_pkg::f_le(a_q, fcmt_pkg::LimI32sLo)) res_d = fcmt_pkg::I32MinBits;
        else res_d = {32'd0, strunc_w[31:0]};
      end
      fcmt_pkg::OP_I32U_T: begin
        if (nan_a || fcmt_pkg::f_le(fcmt_pkg::LimU32Hi, a_q)
            || fcmt_pkg::f_le(a_q, fcmt_pkg::LimULo)) trap_d = 1'b1;
        else res_d = a_q[63] ? 64'd0 : {32'd0, mag_w[31:0]};
      end
      fcmt_pkg::OP_I32U_S: begin
        if (nan_a || a_q[63]) res_d = 64'd0;
        else if (fcmt_pkg::f_le(fcmt_pkg::LimU32Hi, a_q)) res_d = fcmt_pkg::U32MaxBits;
        else res_d = {32'd0, mag_w[31:0]};
      end
      fcmt_pkg::OP_I64S_T: begin
        if (nan_a || fcmt_pkg::f_le(fcmt_pkg::LimI64sHi, a_q)
            || fcmt_pkg::f_le(a_q, fcmt_pkg::LimI64sLo)) trap_d = 1'b1;
        else res_d = strunc_w;
      end
      fcmt_pkg::OP_I64S_S: begin
        if (nan_a) res_d = 64'd0;
        else if (fcmt_pkg::f_le(fcmt_pkg::LimI64sHi, a_q)) res_d = fcmt_pkg::I64MaxBits;
        else if (fcmt_pkg::f_le(a_q, fcmt_pkg::LimI64sLo)) res_d = fcmt_pkg::SignBit;
        else res_d = strunc_w;
      end
      fcmt_pkg::OP_I64U_T: begin
        if (nan_a || fcmt_pkg::f_le(fcmt_pkg::LimU64Hi, a_q)
            || fcmt_pkg::f_le(a_q, fcmt_pkg::LimULo)) trap_d = 1'b1;
        else res_d = a_q[63] ? 64'd0 : mag_w;
      end
      fcmt_pkg::OP_I64U_S: begin
        if (nan_a || a_q[63]) res_d = 64'd0;
        else if (fcmt_pkg::f_le(fcmt_pkg::LimU64Hi, a_q)) res_d = fcmt_pkg::U64MaxBits;
        else res_d = mag_w;
      end
      default: begin
        res_d  = 64'd0;
        trap_d = 1'b0;
      end
    endcase
  end

  // A trap always comes with a zero result.
  a_trap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("trap with nonzero result");

  // A stalled result beat must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed under stall");

  // With the result stage empty the input side is always open.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
endmodule

// ===== rtl/fcmt_trunc.sv =====
// Truncation toward zero of a binary64 magnitude, saturating at all ones.
// Depends on nothing beyond its ports.
module fcmt_trunc (
  input  logic [63:0] value_i,
  output logic [63:0] mag_o
);
  logic [10:0]  exp_w;
  logic [115:0] mant_w;
  logic [11:0]  sh_w;

  assign exp_w  = value_i[62:52];
  assign mant_w = {63'd0, 1'b1, value_i[51:0]};
  assign sh_w   = {1'b0, exp_w} - 12'd1023;

  always_comb begin
    if (exp_w < 11'd1023) begin
      mag_o = 64'd0;
    end else if (exp_w > 11'd1086) begin
      mag_o = '1;
    end else begin
      // Place the mantissa so that bit 52 lands at 2^(exp-1023).
      mag_o = 64'((mant_w << sh_w[5:0]) >> 52);
    end
  end
endmodule
